// ===== design/rtbo_pkg.sv =====
`timescale 1ns / 1ps

package rtbo_pkg;

    localparam int SLOTS      = 32;

    localparam int CMD_W      = 2;
    localparam int SEQ_W      = 32;
    localparam int TIME_W     = 32;
    localparam int RETRY_W    = 8;
    localparam int ITO_W      = 16;
    localparam int EVENT_W    = 3;
    localparam int SLOT_W     = 5;
    localparam int PEND_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT = 1'd1;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST  = 8'd5;
    localparam logic [ITO_W-1:0]   INIT_TIMEOUT_RST = 16'd100;
    localparam logic [TIME_W-1:0]  TIMEOUT_MAX      = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_NAK  = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd;

    typedef enum logic [EVENT_W-1:0] {
        EV_ADDED      = 3'd0,
        EV_FULL       = 3'd1,
        EV_ACKED      = 3'd2,
        EV_ACK_MISS   = 3'd3,
        EV_RETRANSMIT = 3'd4,
        EV_NAK_RESEND = 3'd5,
        EV_NAK_MISS   = 3'd6,
        EV_DROPPED    = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  sent;
        logic [TIME_W-1:0]  timeout;
        logic [RETRY_W-1:0] retries;
    } t_entry;

    // outcome of looking at one slot during a scan
    typedef struct packed {
        logic               fire;
        logic               stop;
        t_event             kind;
        t_event             miss_kind;
        logic               wr_en;
        t_entry             wr_data;
        logic               set_valid;
        logic               clr_valid;
        logic [SEQ_W-1:0]   seq;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  timeout;
    } t_eval;

    typedef struct packed {
        t_event             kind;
        logic [SLOT_W-1:0]  slot;
        logic [SEQ_W-1:0]   seq;
        logic [RETRY_W-1:0] retries;
        logic [TIME_W-1:0]  timeout;
        logic [PEND_W-1:0]  pending;
    } t_result;

endpackage

// ===== design/rtbo_cmd_if.sv =====
`timescale 1ns / 1ps

interface rtbo_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [rtbo_pkg::CMD_W-1:0]  command;
    logic [rtbo_pkg::SEQ_W-1:0]  seq_number;
    logic [rtbo_pkg::TIME_W-1:0] time_now_ms;

    modport source (output valid, output command, output seq_number, output time_now_ms,
                    input ready);
    modport sink   (input valid, input command, input seq_number, input time_now_ms,
                    output ready);
endinterface

// ===== design/rtbo_evt_if.sv =====
`timescale 1ns / 1ps

interface rtbo_evt_if;
    logic                          valid;
    logic                          ready;
    logic [rtbo_pkg::EVENT_W-1:0]  event_kind;
    logic [rtbo_pkg::SLOT_W-1:0]   slot_index;
    logic [rtbo_pkg::SEQ_W-1:0]    seq_out;
    logic [rtbo_pkg::RETRY_W-1:0]  retry_count;
    logic [rtbo_pkg::TIME_W-1:0]   timeout_out_ms;
    logic [rtbo_pkg::PEND_W-1:0]   pending_count;
    logic                          last_of_run;

    modport source (output valid, output event_kind, output slot_index, output seq_out,
                    output retry_count, output timeout_out_ms, output pending_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input slot_index, input seq_out,
                    input retry_count, input timeout_out_ms, input pending_count,
                    input last_of_run, output ready);
endinterface

// ===== design/rtbo_slot_eval.sv =====
`timescale 1ns / 1ps

module rtbo_slot_eval (
    input  rtbo_pkg::t_cmd                      i_cmd,
    input  logic [rtbo_pkg::SEQ_W-1:0]          i_seq,
    input  logic [rtbo_pkg::TIME_W-1:0]         i_now,
    input  rtbo_pkg::t_entry                    i_entry,
    input  logic                                i_valid,
    input  logic [rtbo_pkg::RETRY_W-1:0]        i_retry_limit,
    input  logic [rtbo_pkg::ITO_W-1:0]          i_init_timeout,
    output rtbo_pkg::t_eval                     o_eval
);
    import rtbo_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              seq_hit;
    logic              due;

    assign elapsed = i_now - i_entry.sent;
    assign seq_hit = i_valid && (i_entry.seq == i_seq);
    assign due     = i_valid && (elapsed >= i_entry.timeout);

    always_comb begin
        o_eval           = '0;
        o_eval.kind      = EV_ADDED;
        o_eval.miss_kind = EV_ACK_MISS;
        o_eval.wr_data   = i_entry;
        o_eval.seq       = i_seq;
        o_eval.retries   = i_entry.retries;
        o_eval.timeout   = i_entry.timeout;
        unique case (i_cmd)
            CMD_ADD: begin
                o_eval.miss_kind = EV_FULL;
                if (!i_valid) begin
                    o_eval.fire      = 1'b1;
                    o_eval.stop      = 1'b1;
                    o_eval.kind      = EV_ADDED;
                    o_eval.wr_en     = 1'b1;
                    o_eval.wr_data   = '{seq: i_seq, sent: i_now,
                                         timeout: TIME_W'(i_init_timeout), retries: '0};
                    o_eval.set_valid = 1'b1;
                    o_eval.retries   = '0;
                    o_eval.timeout   = TIME_W'(i_init_timeout);
                end
            end
            CMD_ACK: begin
                o_eval.miss_kind = EV_ACK_MISS;
                if (seq_hit) begin
                    o_eval.fire      = 1'b1;
                    o_eval.stop      = 1'b1;
                    o_eval.kind      = EV_ACKED;
                    o_eval.clr_valid = 1'b1;
                end
            end
            CMD_NAK: begin
                o_eval.miss_kind = EV_NAK_MISS;
                if (seq_hit) begin
                    o_eval.fire         = 1'b1;
                    o_eval.stop         = 1'b1;
                    o_eval.kind         = EV_NAK_RESEND;
                    o_eval.wr_en        = 1'b1;
                    o_eval.wr_data.sent = i_now;
                end
            end
            CMD_TICK: begin
                o_eval.seq = i_entry.seq;
                if (due) begin
                    o_eval.fire = 1'b1;
                    if (i_entry.retries >= i_retry_limit) begin
                        o_eval.kind      = EV_DROPPED;
                        o_eval.clr_valid = 1'b1;
                    end else begin
                        o_eval.kind            = EV_RETRANSMIT;
                        o_eval.wr_en           = 1'b1;
                        o_eval.wr_data.sent    = i_now;
                        o_eval.wr_data.retries = i_entry.retries + RETRY_W'(1);
                        // doubling saturates at the all-ones timeout
                        o_eval.wr_data.timeout = i_entry.timeout[TIME_W-1] ? TIMEOUT_MAX
                                               : {i_entry.timeout[TIME_W-2:0], 1'b0};
                        o_eval.retries         = o_eval.wr_data.retries;
                        o_eval.timeout         = o_eval.wr_data.timeout;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/retransmit_table_with_backoff.sv =====
`timescale 1ns / 1ps

// Retransmission table for unacknowledged messages with exponential backoff.
// Every command walks the slot memory one slot per cycle unless a second result
// stalls on a full output register, with the read issued one slot ahead of the
// read-modify-write; add, ack and nak stop at the first free or matching slot,
// a tick walks all SLOTS slots. A new command is taken only once the block is
// back in idle, after the last result of a run has moved to the output register.
// Results are held one deep so the last one of a run can be flagged. Entry data
// sits in a memory of SLOTS words with separate read and write addresses; valid
// bits and the pending count are flip-flops cleared by reset, so no clearing
// pass is needed.
module retransmit_table_with_backoff (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtbo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rtbo_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rtbo_cmd_if.sink                          i_cmd_ch,
    rtbo_evt_if.source                        o_evt_ch
);
    import rtbo_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_hold_v, n_hold_v;
    t_result             r_hold, n_hold;
    logic                r_out_v, n_out_v;
    t_result             r_out, n_out;
    logic                r_out_last, n_out_last;
    logic [RETRY_W-1:0]  r_retry_limit, n_retry_limit;
    logic [ITO_W-1:0]    r_init_to, n_init_to;

    t_entry              r_mem [SLOTS];
    t_entry              r_rd;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;

    t_eval               ev;
    logic                accept;
    logic                out_free;
    logic                last_slot;
    logic                stall;
    logic                advance;
    logic                done_scan;
    logic                flush_go;
    t_result             new_res;
    t_result             miss_res;

    rtbo_slot_eval u_eval (
        .i_cmd          (r_cmd),
        .i_seq          (r_seq),
        .i_now          (r_now),
        .i_entry        (r_rd),
        .i_valid        (r_valid[r_idx]),
        .i_retry_limit  (r_retry_limit),
        .i_init_timeout (r_init_to),
        .o_eval         (ev)
    );

    assign i_cmd_ch.ready = (r_state == ST_IDLE);
    assign accept         = i_cmd_ch.valid && (r_state == ST_IDLE);
    assign out_free       = !r_out_v || o_evt_ch.ready;
    assign last_slot      = (r_idx == LAST_IDX);
    // a second tick result has to push the held one out first
    assign stall          = (r_state == ST_SCAN) && ev.fire && r_hold_v && !out_free;
    assign advance        = (r_state == ST_SCAN) && !stall;
    assign done_scan      = advance && (ev.stop || last_slot);
    assign flush_go       = (r_state == ST_FLUSH) && (!r_hold_v || out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_SCAN;
            ST_SCAN:  if (done_scan) n_state = ST_FLUSH;
            ST_FLUSH: if (flush_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd         = r_cmd;
        n_seq         = r_seq;
        n_now         = r_now;
        n_idx         = r_idx;
        n_valid       = r_valid;
        n_count       = r_count;
        n_hold_v      = r_hold_v;
        n_hold        = r_hold;
        n_out_v       = r_out_v && !o_evt_ch.ready;
        n_out         = r_out;
        n_out_last    = r_out_last;
        n_retry_limit = r_retry_limit;
        n_init_to     = r_init_to;
        mem_we        = advance && ev.wr_en;
        rd_addr       = '0;

        if (r_state == ST_SCAN) begin
            rd_addr = advance ? r_idx + IDX_W'(1) : r_idx;
        end

        if (accept) begin
            n_cmd = t_cmd'(i_cmd_ch.command);
            n_seq = i_cmd_ch.seq_number;
            n_now = i_cmd_ch.time_now_ms;
            n_idx = '0;
        end

        if (advance) begin
            if (ev.set_valid) begin
                n_valid[r_idx] = 1'b1;
                n_count        = r_count + CNT_W'(1);
            end else if (ev.clr_valid) begin
                n_valid[r_idx] = 1'b0;
                n_count        = r_count - CNT_W'(1);
            end
            if (!done_scan) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end

        new_res  = '{kind: ev.kind, slot: SLOT_W'(r_idx), seq: ev.seq,
                     retries: ev.retries, timeout: ev.timeout, pending: PEND_W'(n_count)};
        miss_res = '{kind: ev.miss_kind, slot: '0, seq: r_seq,
                     retries: '0, timeout: '0, pending: PEND_W'(r_count)};

        if (advance && ev.fire) begin
            if (r_hold_v) begin
                n_out      = r_hold;
                n_out_v    = 1'b1;
                n_out_last = 1'b0;
            end
            n_hold   = new_res;
            n_hold_v = 1'b1;
        end

        // add, ack and nak that found nothing report once at the end
        if (done_scan && !ev.stop && (r_cmd != CMD_TICK)) begin
            n_hold   = miss_res;
            n_hold_v = 1'b1;
        end

        if (flush_go && r_hold_v) begin
            n_out      = r_hold;
            n_out_v    = 1'b1;
            n_out_last = 1'b1;
            n_hold_v   = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RETRY_LIMIT:  n_retry_limit = i_cfg_data[RETRY_W-1:0];
                REG_INIT_TIMEOUT: n_init_to     = i_cfg_data[ITO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_valid       <= '0;
            r_count       <= '0;
            r_hold_v      <= 1'b0;
            r_out_v       <= 1'b0;
            r_idx         <= '0;
            r_retry_limit <= RETRY_LIMIT_RST;
            r_init_to     <= INIT_TIMEOUT_RST;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_count       <= n_count;
            r_hold_v      <= n_hold_v;
            r_out_v       <= n_out_v;
            r_idx         <= n_idx;
            r_retry_limit <= n_retry_limit;
            r_init_to     <= n_init_to;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_seq      <= n_seq;
        r_now      <= n_now;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= ev.wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_evt_ch.valid          = r_out_v;
    assign o_evt_ch.event_kind     = r_out.kind;
    assign o_evt_ch.slot_index     = r_out.slot;
    assign o_evt_ch.seq_out        = r_out.seq;
    assign o_evt_ch.retry_count    = r_out.retries;
    assign o_evt_ch.timeout_out_ms = r_out.timeout;
    assign o_evt_ch.pending_count  = r_out.pending;
    assign o_evt_ch.last_of_run    = r_out_last;

endmodule

// ===== tb/tb_retransmit_checker.sv =====
`timescale 1ns / 1ps

module tb_retransmit_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rtbo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtbo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rtbo_cmd_if                             i_cmd_ch,
    rtbo_evt_if                             i_evt_ch,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import rtbo_pkg::*;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_awaited;

    logic [RETRY_W-1:0] retry_limit_q;
    logic [ITO_W-1:0]   init_timeout_q;
    logic               slot_live[SLOTS];
    t_entry             slot_entry[SLOTS];
    t_awaited           awaited_events[$];
    int                 mismatches = 0;

    function automatic logic [PEND_W-1:0] live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) n++;
        end
        return PEND_W'(n);
    endfunction

    function automatic int lowest_match(logic [SEQ_W-1:0] seq);
        int hit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_live[i] && slot_entry[i].seq == seq) hit = i;
        end
        return hit;
    endfunction

    // pending count is taken after the table has been updated
    function automatic void await_event(t_event kind, int slot, logic [SEQ_W-1:0] seq,
                                        logic [RETRY_W-1:0] retries,
                                        logic [TIME_W-1:0] timeout);
        t_awaited e;
        e.res.kind    = kind;
        e.res.slot    = SLOT_W'(slot);
        e.res.seq     = seq;
        e.res.retries = retries;
        e.res.timeout = timeout;
        e.res.pending = live_count();
        e.last        = 1'b0;
        awaited_events.push_back(e);
    endfunction

    function automatic void predict_command(t_cmd cmd, logic [SEQ_W-1:0] seq,
                                            logic [TIME_W-1:0] now);
        int                hit;
        int                made;
        logic [TIME_W-1:0] elapsed;
        t_awaited          tail;
        hit  = -1;
        made = 0;
        case (cmd)
            CMD_ADD: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && !slot_live[i]) hit = i;
                end
                if (hit < 0) begin
                    await_event(EV_FULL, 0, seq, '0, '0);
                end else begin
                    slot_live[hit]  = 1'b1;
                    slot_entry[hit] = '{seq: seq, sent: now, timeout: TIME_W'(init_timeout_q),
                                        retries: '0};
                    await_event(EV_ADDED, hit, seq, '0, TIME_W'(init_timeout_q));
                end
                made = 1;
            end
            CMD_ACK, CMD_NAK: begin
                hit = lowest_match(seq);
                if (hit < 0) begin
                    await_event((cmd == CMD_ACK) ? EV_ACK_MISS : EV_NAK_MISS, 0, seq, '0, '0);
                end else if (cmd == CMD_ACK) begin
                    slot_live[hit] = 1'b0;
                    await_event(EV_ACKED, hit, seq, slot_entry[hit].retries,
                                slot_entry[hit].timeout);
                end else begin
                    // nak only restamps the send time
                    slot_entry[hit].sent = now;
                    await_event(EV_NAK_RESEND, hit, seq, slot_entry[hit].retries,
                                slot_entry[hit].timeout);
                end
                made = 1;
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i]) begin
                        elapsed = now - slot_entry[i].sent;
                        if (elapsed >= slot_entry[i].timeout) begin
                            if (slot_entry[i].retries >= retry_limit_q) begin
                                slot_live[i] = 1'b0;
                                await_event(EV_DROPPED, i, slot_entry[i].seq,
                                            slot_entry[i].retries, slot_entry[i].timeout);
                            end else begin
                                slot_entry[i].retries = slot_entry[i].retries + RETRY_W'(1);
                                if (slot_entry[i].timeout > (TIMEOUT_MAX >> 1)) begin
                                    slot_entry[i].timeout = TIMEOUT_MAX;
                                end else begin
                                    slot_entry[i].timeout = slot_entry[i].timeout << 1;
                                end
                                slot_entry[i].sent = now;
                                await_event(EV_RETRANSMIT, i, slot_entry[i].seq,
                                            slot_entry[i].retries, slot_entry[i].timeout);
                            end
                            made++;
                        end
                    end
                end
            end
        endcase
        if (made > 0) begin
            tail      = awaited_events.pop_back();
            tail.last = 1'b1;
            awaited_events.push_back(tail);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_awaited want;
        if (!i_rst_n) begin
            retry_limit_q  = RETRY_LIMIT_RST;
            init_timeout_q = INIT_TIMEOUT_RST;
            for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
            awaited_events.delete();
        end else begin
            // results first: a command taken at this edge cannot produce one yet
            if (i_evt_ch.valid && i_evt_ch.ready) begin
                if (awaited_events.size() == 0) begin
                    $error("event_kind: expected none, actual %0d (slot %0d seq %0d)",
                           i_evt_ch.event_kind, i_evt_ch.slot_index, i_evt_ch.seq_out);
                    mismatches++;
                end else begin
                    want = awaited_events.pop_front();
                    check_field("event_kind", want.res.kind, i_evt_ch.event_kind);
                    check_field("slot_index", want.res.slot, i_evt_ch.slot_index);
                    check_field("seq_out", want.res.seq, i_evt_ch.seq_out);
                    check_field("retry_count", want.res.retries, i_evt_ch.retry_count);
                    check_field("timeout_out_ms", want.res.timeout, i_evt_ch.timeout_out_ms);
                    check_field("pending_count", want.res.pending, i_evt_ch.pending_count);
                    check_field("last_of_run", want.last, i_evt_ch.last_of_run);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_RETRY_LIMIT) begin
                    retry_limit_q = i_cfg_data[RETRY_W-1:0];
                end else if (i_cfg_idx == REG_INIT_TIMEOUT) begin
                    init_timeout_q = i_cfg_data[ITO_W-1:0];
                end
            end
            if (i_cmd_ch.valid && i_cmd_ch.ready) begin
                predict_command(t_cmd'(i_cmd_ch.command), i_cmd_ch.seq_number,
                                i_cmd_ch.time_now_ms);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= awaited_events.size();
    end

endmodule

// ===== tb/tb_retransmit_table_with_backoff.sv =====
`timescale 1ns / 1ps

module tb_retransmit_table_with_backoff;
    import rtbo_pkg::*;

    localparam int SLOT_COUNT     = SLOTS;
    localparam int SCAN_CYCLES    = SLOT_COUNT + 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rtbo_cmd_if cmd_ch();
    rtbo_evt_if evt_ch();

    int                fail_count;
    int                outstanding;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    bit                rx_hold_req;
    logic [TIME_W-1:0] now_ms;
    logic [ITO_W-1:0]  cur_timeout;
    logic [SEQ_W-1:0]  live_seqs[$];

    retransmit_table_with_backoff i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd_ch  (cmd_ch),
        .o_evt_ch  (evt_ch)
    );

    tb_retransmit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_ch     (cmd_ch),
        .i_evt_ch     (evt_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // event side: random stall bursts, plus one long hold-off on request
    initial begin : event_sink
        int unsigned stall_left;
        stall_left   = 0;
        evt_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                if (rx_hold_req) begin
                    rx_hold_req = 1'b0;
                    stall_left  = HOLD_CYCLES;
                end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                    stall_left = $urandom_range(1, 13);
                end
            end
            if (stall_left != 0) begin
                evt_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                evt_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // returns at the edge where the transaction is taken
    task automatic issue(t_cmd cmd, logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] stamp);
        int unsigned gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 13);
            cmd_ch.valid       <= 1'b0;
            cmd_ch.command     <= 2'($urandom);
            cmd_ch.seq_number  <= $urandom;
            cmd_ch.time_now_ms <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.seq_number  <= seq;
        cmd_ch.time_now_ms <= stamp;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // quiet the command side until every event is in, then let a scan finish
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SCAN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [RETRY_W-1:0] limit, logic [ITO_W-1:0] timeout);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_RETRY_LIMIT;
        i_cfg_data <= {8'($urandom), limit};
        @(posedge i_clk);
        i_cfg_idx  <= REG_INIT_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_timeout = timeout;
    endtask

    task automatic random_traffic(int unsigned count);
        int unsigned      pick;
        int               idx;
        logic [SEQ_W-1:0] seq;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                now_ms = $urandom;
            end else begin
                now_ms += $urandom_range(0, 2 * cur_timeout + 20);
            end
            if (pick < 30) begin
                // small sequence numbers make duplicates likely
                if ($urandom_range(0, 2) == 0) seq = SEQ_W'($urandom_range(0, 15));
                else seq = $urandom;
                if (live_seqs.size() < 40) live_seqs.push_back(seq);
                issue(CMD_ADD, seq, now_ms);
            end else if (pick < 70) begin
                if (live_seqs.size() != 0 && $urandom_range(0, 4) != 0) begin
                    idx = $urandom_range(0, live_seqs.size() - 1);
                    seq = live_seqs[idx];
                    if (pick < 55) live_seqs.delete(idx);
                end else begin
                    seq = $urandom;
                end
                issue((pick < 55) ? CMD_ACK : CMD_NAK, seq, now_ms);
            end else begin
                issue(CMD_TICK, $urandom, now_ms);
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_ADD;
        cmd_ch.seq_number  = '0;
        cmd_ch.time_now_ms = '0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        rx_hold_req        = 1'b0;
        now_ms             = '0;
        cur_timeout        = INIT_TIMEOUT_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: duplicates, misses, wrapped time, quiet and busy ticks
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        issue(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        issue(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        issue(CMD_ADD, 32'h0000_0000, 32'd10);
        issue(CMD_NAK, 32'h0000_0000, 32'd50);
        issue(CMD_NAK, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        issue(CMD_ACK, 32'h1234_5678, 32'd60);
        issue(CMD_TICK, 32'hFFFF_FFFF, 32'd50);
        issue(CMD_TICK, 32'h0000_0000, 32'h0000_0054);
        issue(CMD_TICK, 32'hA5A5_A5A5, 32'd160);
        issue(CMD_ACK, 32'h0000_0000, 32'd170);
        issue(CMD_ACK, 32'h0000_0000, 32'd171);
        issue(CMD_ACK, 32'h0000_0000, 32'd172);
        issue(CMD_ACK, 32'hFFFF_FFFF, 32'd173);
        settle();

        // no retries allowed: first expiry drops
        configure(8'd0, 16'd1);
        issue(CMD_ADD, 32'd7, 32'd1000);
        issue(CMD_TICK, 32'd0, 32'd1001);
        settle();

        // zero initial timeout is due at once and stays zero when doubled
        configure(8'd1, 16'd0);
        issue(CMD_ADD, 32'd8, 32'd2000);
        issue(CMD_TICK, 32'd0, 32'd2000);
        issue(CMD_TICK, 32'd0, 32'd2000);
        settle();

        // walk one entry up to timeout saturation, then past its retry limit
        configure(8'd20, 16'hFFFF);
        now_ms = 32'h8000_0000;
        issue(CMD_ADD, 32'hC0DE_0001, now_ms);
        repeat (22) begin
            now_ms -= 1;
            issue(CMD_TICK, $urandom, now_ms);
        end
        settle();

        // hold the event side while adds keep coming: fills the table and backs up
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(8'd3, 16'hFFFF);
        rx_hold_req = 1'b1;
        for (int k = 0; k < SLOT_COUNT + 8; k++) begin
            issue(CMD_ADD, 32'hA000_0000 + k, now_ms);
        end
        settle();
        for (int k = SLOT_COUNT + 7; k >= 0; k--) begin
            issue(CMD_ACK, 32'hA000_0000 + k, now_ms);
        end
        settle();

        tx_idle_pct = 30;
        rx_idle_pct = 10;
        configure(8'd5, 16'd100);
        random_traffic(50);
        settle();

        tx_idle_pct = 10;
        rx_idle_pct = 50;
        configure(8'd255, 16'd1);
        random_traffic(40);
        settle();

        tx_idle_pct = 50;
        rx_idle_pct = 20;
        configure(8'd0, 16'($urandom_range(1, 300)));
        random_traffic(40);
        settle();

        tx_idle_pct = 20;
        rx_idle_pct = 30;
        configure(8'd2, 16'hFFFF);
        random_traffic(40);
        settle();

        // closing stretch runs flat out on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(8'($urandom_range(1, 6)), 16'($urandom_range(20, 200)));
        random_traffic(60);
        settle();

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rtbo_pkg.sv
design/rtbo_cmd_if.sv
design/rtbo_evt_if.sv
design/rtbo_slot_eval.sv
design/retransmit_table_with_backoff.sv
tb/tb_retransmit_checker.sv
tb/tb_retransmit_table_with_backoff.sv
